// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

  localparam int ROUTINE_DEPTH = 768;
  localparam int ERROR_DEPTH   = 256;
  localparam int STORE_DEPTH   = ROUTINE_DEPTH + ERROR_DEPTH;

  localparam int ROUTINE_AW = (ROUTINE_DEPTH > 1) ? $clog2(ROUTINE_DEPTH) : 1;
  localparam int ERROR_AW   = (ERROR_DEPTH > 1) ? $clog2(ERROR_DEPTH) : 1;
  localparam int STORE_AW   = $clog2(STORE_DEPTH);
  // wide enough for any slot, head or region bound in an unsigned compare
  localparam int CMP_W      = $clog2(STORE_DEPTH) + 2;

  localparam int OP_W        = 2;
  localparam int ERRNO_W     = 32;
  localparam int RET_W       = 64;
  localparam int DISP_W      = 2;
  localparam int PAYLOAD_W   = 64;
  localparam int SLOT_W      = 10;
  localparam int SEQ_W       = 64;
  localparam int PCT_W       = 7;
  localparam int SEED_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_SYSCALL = 2'd0,
    OP_PROCESS = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  localparam logic [DISP_W-1:0] DISP_NOSYS = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERCENT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED    = 8'd1;

  localparam logic [PCT_W-1:0]  RESET_PERCENT = 7'd1;
  localparam logic [PCT_W-1:0]  PCT_ALL       = 7'd100;
  localparam logic [SEED_W-1:0] RESET_SEED    = 32'd1;

  // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x
  localparam logic [SEED_W-1:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int                DIV100_SHIFT = 37;
  localparam int                QUOT_W       = 2 * SEED_W - DIV100_SHIFT;
  localparam logic [SEED_W-1:0] MOD_BASE     = 32'd100;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ROUTINE,
    KIND_ERROR,
    KIND_READ
  } kind_t;

  // input word, error_number in the lowest bits
  typedef struct packed {
    logic [2:0]              pad;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_W-1:0]    payload;
    logic                    is_rare;
    logic [DISP_W-1:0]       disposition;
    logic signed [RET_W-1:0] ret_val;
    logic signed [ERRNO_W-1:0] error_number;
  } in_word_t;

  // result word, stored in the lowest bit
  typedef struct packed {
    logic [4:0]           pad;
    logic [PAYLOAD_W-1:0] read_payload;
    logic [SEQ_W-1:0]     sequence_res;
    logic [SLOT_W-1:0]    entry_slot;
    logic                 stored;
  } out_word_t;

  localparam int IN_DATA_W  = $bits(in_word_t);
  localparam int OUT_DATA_W = $bits(out_word_t);

  typedef struct packed {
    kind_t                kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    slot;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq_num;
    logic [PAYLOAD_W-1:0] data;
  } entry_t;

  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== rtl/sampled_split_trace_ring_top.sv =====
// channel  | dir | valid/ready                  | payload
// ---------+-----+------------------------------+--------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata event fields, tuser op
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata one result word per input word
// cfg      | in  | cfg_valid/cfg_ready          | cfg_index register, cfg_data value
//
// Front: one word per cycle while the queue accepts; a sampled call holds off
// new words through draw, multiply by the reciprocal of 100, remainder compare.
// Back: a push completes in the idle state, a read adds a state for the registered
// memory read. A two-word queue lets either side stall alone; the result register
// takes a new word while the previous one is taken. Synchronous reset; the store
// needs no clearing pass, per-ring wrap marks make unreached slots read as empty.
module sampled_split_trace_ring_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // error_number, ret_val, disposition, is_rare, payload, slot, zero pad
  input  logic [ssr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [ssr_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // stored, entry_slot, sequence_res, read_payload, zero pad
  output logic [ssr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic               cmd_valid;
  logic               cmd_ready;
  ssr_pkg::cmd_t      cmd;
  logic               q_valid;
  logic               q_ready;
  ssr_pkg::cmd_t      q_cmd;
  ssr_pkg::out_word_t res;

  ssr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  ssr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_valid),
    .in_ready  (cmd_ready),
    .in_cmd    (cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  ssr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = ssr_pkg::OUT_DATA_W'(res);

endmodule

// ===== rtl/ssr_front.sv =====
module ssr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ssr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [ssr_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output ssr_pkg::cmd_t                   cmd
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DECIDE
  } fstate_t;

  fstate_t                         state;
  logic [ssr_pkg::PCT_W-1:0]       sample_percent;
  logic [ssr_pkg::SEED_W-1:0]      generator;
  logic [2*ssr_pkg::SEED_W-1:0]    product;

  ssr_pkg::in_word_t               in_word;
  ssr_pkg::kind_t                  kind_in;
  logic                            need_draw;
  logic                            is_err;
  logic                            accept;
  logic                            draw_take;
  logic                            cmd_issue;
  logic                            seed_wr;
  logic [ssr_pkg::QUOT_W-1:0]      quot;
  logic [ssr_pkg::SEED_W-1:0]      quot_x100;
  logic [ssr_pkg::SEED_W-1:0]      rem;
  logic                            keep;

  assign in_word   = ssr_pkg::in_word_t'(s_axis_tdata);
  assign cfg_ready = 1'b1;

  assign s_axis_tready = (state == F_IDLE) && (!cmd_valid || cmd_ready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign draw_take     = accept && need_draw;
  assign cmd_issue     = (accept && !need_draw) || (state == F_DECIDE);
  assign seed_wr       = cfg_valid && cfg_ready && (cfg_index == ssr_pkg::REG_RANDOM_SEED);

  assign is_err = (in_word.error_number != '0) || in_word.ret_val[ssr_pkg::RET_W-1] ||
                  (in_word.disposition == ssr_pkg::DISP_NOSYS);

  always_comb begin
    kind_in   = ssr_pkg::KIND_NONE;
    need_draw = 1'b0;
    unique case (s_axis_tuser)
      ssr_pkg::OP_SYSCALL: begin
        if (is_err) begin
          kind_in = ssr_pkg::KIND_ERROR;
        end else if (in_word.is_rare || sample_percent >= ssr_pkg::PCT_ALL) begin
          kind_in = ssr_pkg::KIND_ROUTINE;
        end else if (sample_percent != '0) begin
          need_draw = 1'b1;
        end
      end
      ssr_pkg::OP_PROCESS: kind_in = ssr_pkg::KIND_ERROR;
      ssr_pkg::OP_READ:    kind_in = ssr_pkg::KIND_READ;
      default:             kind_in = ssr_pkg::KIND_NONE;
    endcase
  end

  // draw % 100 by reciprocal multiply; generator holds the draw
  assign quot      = product[2*ssr_pkg::SEED_W-1:ssr_pkg::DIV100_SHIFT];
  assign quot_x100 = ssr_pkg::SEED_W'(quot) * ssr_pkg::MOD_BASE;
  assign rem       = generator - quot_x100;
  assign keep      = rem < ssr_pkg::SEED_W'(sample_percent);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      cmd_valid      <= 1'b0;
      sample_percent <= ssr_pkg::RESET_PERCENT;
      generator      <= ssr_pkg::RESET_SEED;
    end else begin
      if (cmd_issue) begin
        cmd_valid <= 1'b1;
      end else if (cmd_valid && cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            cmd.payload <= in_word.payload;
            cmd.slot    <= in_word.slot;
            if (need_draw) begin
              state    <= F_MUL;
            end else begin
              cmd.kind <= kind_in;
            end
          end
        end
        F_MUL: begin
          product <= {{ssr_pkg::SEED_W{1'b0}}, generator} *
                     {{ssr_pkg::SEED_W{1'b0}}, ssr_pkg::DIV100_MAGIC};
          state   <= F_DECIDE;
        end
        F_DECIDE: begin
          cmd.kind <= keep ? ssr_pkg::KIND_ROUTINE : ssr_pkg::KIND_NONE;
          state    <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
      if (cfg_valid && cfg_ready && cfg_index == ssr_pkg::REG_SAMPLE_PERCENT) begin
        sample_percent <= cfg_data[ssr_pkg::PCT_W-1:0];
      end
      if (seed_wr) begin
        generator <= cfg_data[ssr_pkg::SEED_W-1:0];
      end else if (draw_take) begin
        generator <= ssr_pkg::xorshift32(generator);
      end
    end
  end

  a_decide_issues: assert property (@(posedge clk) disable iff (rst)
    (state == F_DECIDE) |=> cmd_valid)
    else $error("sampling decision did not issue a command");

endmodule

// ===== rtl/ssr_fifo.sv =====
module ssr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssr_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output ssr_pkg::cmd_t out_cmd
);

  ssr_pkg::cmd_t                 entries [ssr_pkg::QUEUE_DEPTH];
  logic [ssr_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [ssr_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [ssr_pkg::QUEUE_AW:0]    count;
  logic                          push;
  logic                          pop;

  assign in_ready  = count != (ssr_pkg::QUEUE_AW + 1)'(ssr_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ssr_pkg::QUEUE_AW'(ssr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ssr_pkg::QUEUE_AW'(ssr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ssr_back.sv =====
module ssr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  ssr_pkg::cmd_t      q_cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output ssr_pkg::out_word_t res
);

  typedef enum logic {
    B_IDLE,
    B_READ
  } bstate_t;

  bstate_t                          state;
  ssr_pkg::entry_t                  mem [ssr_pkg::STORE_DEPTH];
  ssr_pkg::entry_t                  rd_entry;
  logic [ssr_pkg::ROUTINE_AW-1:0]   norm_head;
  logic [ssr_pkg::ERROR_AW-1:0]     fault_head;
  logic                             routine_full;
  logic                             error_full;
  logic [ssr_pkg::SEQ_W-1:0]        last_sequence;
  logic                             rd_inrange;
  logic                             rd_written;
  logic [ssr_pkg::SLOT_W-1:0]       rd_slot;

  logic                             out_free;
  logic                             pop;
  logic                             wr_en;
  logic                             rd_en;
  logic [ssr_pkg::STORE_AW-1:0]     wr_addr;
  logic [ssr_pkg::STORE_AW-1:0]     routine_addr;
  logic [ssr_pkg::STORE_AW-1:0]     error_addr;
  logic [ssr_pkg::SEQ_W-1:0]        seq_new;
  logic [ssr_pkg::CMP_W-1:0]        slot_ext;
  logic [ssr_pkg::CMP_W-1:0]        err_idx;
  logic                             in_routine;
  logic                             in_store;
  logic                             written;
  ssr_pkg::out_word_t               res_next;
  logic                             res_load;

  assign out_free = !res_valid || res_ready;
  assign q_ready  = (state == B_IDLE) && out_free;
  assign pop      = q_valid && q_ready;
  assign seq_new  = last_sequence + 64'd1;

  assign routine_addr = ssr_pkg::STORE_AW'(norm_head);
  assign error_addr   = ssr_pkg::STORE_AW'(ssr_pkg::ROUTINE_DEPTH) +
                        ssr_pkg::STORE_AW'(fault_head);
  assign wr_en   = pop && (q_cmd.kind == ssr_pkg::KIND_ROUTINE ||
                           q_cmd.kind == ssr_pkg::KIND_ERROR);
  assign wr_addr = (q_cmd.kind == ssr_pkg::KIND_ROUTINE) ? routine_addr : error_addr;
  assign rd_en   = pop && (q_cmd.kind == ssr_pkg::KIND_READ);

  // a slot holds data only once its ring has reached it; otherwise it reads as empty
  assign slot_ext   = ssr_pkg::CMP_W'(q_cmd.slot);
  assign in_routine = slot_ext < ssr_pkg::CMP_W'(ssr_pkg::ROUTINE_DEPTH);
  assign in_store   = slot_ext < ssr_pkg::CMP_W'(ssr_pkg::STORE_DEPTH);
  assign err_idx    = slot_ext - ssr_pkg::CMP_W'(ssr_pkg::ROUTINE_DEPTH);
  assign written    = in_routine ?
                      (routine_full || slot_ext < ssr_pkg::CMP_W'(norm_head)) :
                      (error_full || err_idx < ssr_pkg::CMP_W'(fault_head));

  always_comb begin
    res_next = '0;
    res_load = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          unique case (q_cmd.kind)
            ssr_pkg::KIND_ROUTINE: begin
              res_next.stored       = 1'b1;
              res_next.entry_slot   = ssr_pkg::SLOT_W'(routine_addr);
              res_next.sequence_res = seq_new;
              res_load              = 1'b1;
            end
            ssr_pkg::KIND_ERROR: begin
              res_next.stored       = 1'b1;
              res_next.entry_slot   = ssr_pkg::SLOT_W'(error_addr);
              res_next.sequence_res = seq_new;
              res_load              = 1'b1;
            end
            ssr_pkg::KIND_READ: res_load = 1'b0;
            default:            res_load = 1'b1;
          endcase
        end
      end
      B_READ: begin
        res_next.stored       = rd_inrange;
        res_next.entry_slot   = rd_slot;
        res_next.sequence_res = rd_written ? rd_entry.seq_num : '0;
        res_next.read_payload = rd_written ? rd_entry.data : '0;
        res_load              = out_free;
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{seq_num: seq_new, data: q_cmd.payload};
    end
    if (rd_en) begin
      rd_entry <= mem[q_cmd.slot[ssr_pkg::STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      res_valid     <= 1'b0;
      norm_head     <= '0;
      fault_head    <= '0;
      routine_full  <= 1'b0;
      error_full    <= 1'b0;
      last_sequence <= '0;
    end else begin
      if (res_load) begin
        res       <= res_next;
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (wr_en) begin
        last_sequence <= seq_new;
      end
      if (wr_en && q_cmd.kind == ssr_pkg::KIND_ROUTINE) begin
        if (norm_head == ssr_pkg::ROUTINE_AW'(ssr_pkg::ROUTINE_DEPTH - 1)) begin
          norm_head    <= '0;
          routine_full <= 1'b1;
        end else begin
          norm_head <= norm_head + 1'b1;
        end
      end
      if (wr_en && q_cmd.kind == ssr_pkg::KIND_ERROR) begin
        if (fault_head == ssr_pkg::ERROR_AW'(ssr_pkg::ERROR_DEPTH - 1)) begin
          fault_head <= '0;
          error_full <= 1'b1;
        end else begin
          fault_head <= fault_head + 1'b1;
        end
      end
      unique case (state)
        B_IDLE: begin
          if (rd_en) begin
            rd_inrange <= in_store;
            rd_written <= in_store && written;
            rd_slot    <= q_cmd.slot;
            state      <= B_READ;
          end
        end
        B_READ: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> last_sequence == $past(last_sequence) + 64'd1)
    else $error("sequence did not advance by one on a push");

  a_routine_full_holds: assert property (@(posedge clk) disable iff (rst)
    routine_full |=> routine_full)
    else $error("routine ring lost its wrapped mark");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    ssr_pkg::CMP_W'(norm_head) < ssr_pkg::CMP_W'(ssr_pkg::ROUTINE_DEPTH))
    else $error("routine head beyond its region");

endmodule
